// ===== rtl/brrf_pkg.sv =====
// Package for the rectangle region finder: sizes, register indexes,
// controller states and the structs shared by the top level and the judge.
// No dependencies.
`default_nettype none
package brrf_pkg;

  localparam int MAX_WIDTH    = 64;
  localparam int MAX_HEIGHT   = 64;
  localparam int MAX_OPEN     = 32;
  localparam int RESULT_LIMIT = 32;

  localparam int COL_W   = $clog2(MAX_WIDTH);
  localparam int ROW_W   = $clog2(MAX_HEIGHT);
  localparam int DIM_W   = 7;
  localparam int AREA_W  = 13;
  localparam int NUM_W   = 12;
  localparam int FOUND_W = 11;
  localparam int CNT_W   = $clog2(MAX_OPEN + 1);
  localparam int CFG_IDX_W = 1;

  localparam logic [DIM_W-1:0]   HEIGHT_SAT = DIM_W'(127);
  localparam logic [DIM_W-1:0]   RUN_SAT    = DIM_W'(127);
  localparam logic [FOUND_W-1:0] FOUND_SAT  = FOUND_W'(2047);

  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH  = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT = CFG_IDX_W'(1);

  typedef enum logic [3:0] {
    S_IDLE,
    S_UPPER,
    S_SCAN,
    S_PROC,
    S_OPEN,
    S_FLUSH_SCAN,
    S_FLUSH_PROC,
    S_CLEAR,
    S_LAST
  } state_t;

  typedef struct packed {
    logic [ROW_W-1:0] top;
    logic [DIM_W-1:0] span;
    logic [DIM_W-1:0] height;
    logic             row_ok;
  } entry_t;

  typedef struct packed {
    logic [COL_W-1:0] col;
    logic             pix;
    logic             row_end;
  } pos_t;

  typedef struct packed {
    entry_t entry;
    logic   emit;
  } judge_t;

  typedef struct packed {
    logic [ROW_W-1:0]  top_row;
    logic [COL_W-1:0]  left_col;
    logic [DIM_W-1:0]  region_width;
    logic [DIM_W-1:0]  region_height;
    logic [AREA_W-1:0] region_area;
    logic [NUM_W-1:0]  region_number;
  } rec_t;

endpackage
`default_nettype wire

// ===== rtl/brrf_if.sv =====
// Valid/ready channels for the pixel input and the region record output.
// Depends on brrf_pkg for field widths.
`default_nettype none
interface brrf_in_if;
  logic valid;
  logic ready;
  logic pixel;
  modport source (output valid, output pixel, input ready);
  modport sink (input valid, input pixel, output ready);
endinterface

interface brrf_out_if import brrf_pkg::*; ;
  logic                valid;
  logic                ready;
  logic [ROW_W-1:0]    top_row;
  logic [COL_W-1:0]    left_col;
  logic [DIM_W-1:0]    region_width;
  logic [DIM_W-1:0]    region_height;
  logic [AREA_W-1:0]   region_area;
  logic [NUM_W-1:0]    region_number;
  logic                last_of_run;
  modport source (output valid, output top_row, output left_col, output region_width,
                  output region_height, output region_area, output region_number,
                  output last_of_run, input ready);
  modport sink (input valid, input top_row, input left_col, input region_width,
                input region_height, input region_area, input region_number,
                input last_of_run, output ready);
endinterface
`default_nettype wire

// ===== rtl/brrf_judge.sv =====
// Judges one open region entry against the current pixel position.
// Depends on brrf_pkg.
`default_nettype none
module brrf_judge import brrf_pkg::*; (
  input  wire logic [COL_W-1:0] entry_col,
  input  wire entry_t           entry,
  input  wire pos_t             pos,
  output judge_t                result
);

  logic [COL_W+1:0] end_c;
  logic [COL_W+1:0] col_c;
  logic             ok;
  logic             decide;

  always_comb begin
    end_c  = (COL_W+2)'(entry_col) + (COL_W+2)'(entry.span) - (COL_W+2)'(1);
    col_c  = (COL_W+2)'(pos.col);
    // A zero anywhere in the span spoils this row.
    ok     = entry.row_ok &&
             !((entry_col <= pos.col) && (col_c <= end_c) && !pos.pix);
    decide = (col_c == end_c) || (pos.row_end && (end_c > col_c));
    result.entry = entry;
    result.emit  = 1'b0;
    if (decide) begin
      if (ok) begin
        if (entry.height < HEIGHT_SAT) begin
          result.entry.height = entry.height + DIM_W'(1);
        end
      end else begin
        result.emit = 1'b1;
      end
      result.entry.row_ok = 1'b1;
    end else begin
      result.entry.row_ok = ok;
    end
  end

endmodule
`default_nettype wire

// ===== rtl/binary_rectangle_region_finder.sv =====
// Rectangle region finder over a binary raster image, one pixel per word.
// Each pixel is handled by a sweep over all 64 entries of the open-region
// memory; the last pixel of a frame adds a second sweep. Each emitted record
// may hold the sweep while the output is stalled. A new pixel is taken only
// when the previous one is finished. Reset (synchronous, rst_n low) empties
// the frame state.
`default_nettype none
module binary_rectangle_region_finder import brrf_pkg::*; (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  brrf_in_if.sink                   in_ch,
  brrf_out_if.source                out_ch,
  input  wire logic                 cfg_we,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [DIM_W-1:0]     cfg_data
);

  // Configuration registers hold the raw values; they are clamped on use.
  logic [DIM_W-1:0] width_cfg_r, height_cfg_r;
  logic [DIM_W-1:0] w_eff, h_eff;

  state_t state_r, state_nxt;

  // Frame position and run tracking.
  logic [COL_W-1:0]   col_r, col_nxt;
  logic [ROW_W-1:0]   row_r, row_nxt;
  logic               left_r, left_nxt;
  logic [COL_W-1:0]   run_start_r, run_start_nxt;
  logic [DIM_W-1:0]   run_len_r, run_len_nxt;
  logic               run_opens_r, run_opens_nxt;
  logic [FOUND_W-1:0] found_r, found_nxt;
  logic               pix_r, pix_nxt;
  logic               upper_r, upper_nxt;
  logic [COL_W-1:0]   idx_r, idx_nxt;
  logic [CNT_W-1:0]   count_r, count_nxt;
  // Records already emitted for the current pixel; any beyond the limit are
  // dropped without a number.
  logic [CNT_W-1:0]   emits_r, emits_nxt;

  // Valid bits for the open-region memory and for the previous line.
  logic [MAX_WIDTH-1:0] valid_r, valid_nxt;
  logic [MAX_WIDTH-1:0] uvalid_r, uvalid_nxt;

  // The open-region memory is indexed by the left column of each region.
  entry_t           omem [MAX_WIDTH];
  entry_t           ord_r;
  logic             o_re, o_we;
  logic [COL_W-1:0] o_waddr;
  entry_t           o_wdata;

  // The previous image line.
  logic             umem [MAX_WIDTH];
  logic             urd_r;
  logic             u_re, u_we;

  // A finished record waits in the pending register until the next one, or
  // the end of the pixel, shows whether it is the last for this pixel.
  logic pend_v_r, pend_v_nxt;
  rec_t pend_r, pend_nxt;
  logic out_valid_r, out_valid_nxt;
  rec_t out_rec_r, out_rec_nxt;
  logic out_last_r, out_last_nxt;
  logic out_free;

  logic             row_end, frame_end;
  pos_t             pos;
  judge_t           judge;
  logic             emit_go;
  rec_t             emit_rec;
  logic [2*DIM_W-1:0] prod;

  always_comb begin
    if (width_cfg_r == '0) begin
      w_eff = DIM_W'(1);
    end else if (width_cfg_r > DIM_W'(MAX_WIDTH)) begin
      w_eff = DIM_W'(MAX_WIDTH);
    end else begin
      w_eff = width_cfg_r;
    end
    if (height_cfg_r == '0) begin
      h_eff = DIM_W'(1);
    end else if (height_cfg_r > DIM_W'(MAX_HEIGHT)) begin
      h_eff = DIM_W'(MAX_HEIGHT);
    end else begin
      h_eff = height_cfg_r;
    end
  end

  assign row_end   = DIM_W'(col_r) >= (w_eff - DIM_W'(1));
  assign frame_end = row_end && (DIM_W'(row_r) >= (h_eff - DIM_W'(1)));
  assign out_free  = !out_valid_r || out_ch.ready;

  assign pos.col     = col_r;
  assign pos.pix     = pix_r;
  assign pos.row_end = row_end;

  brrf_judge u_judge (
    .entry_col (idx_r),
    .entry     (ord_r),
    .pos       (pos),
    .result    (judge)
  );

  assign prod = ord_r.span * ord_r.height;
  always_comb begin
    emit_rec.top_row       = ord_r.top;
    emit_rec.left_col      = idx_r;
    emit_rec.region_width  = ord_r.span;
    emit_rec.region_height = ord_r.height;
    emit_rec.region_area   = prod[AREA_W-1:0];
    emit_rec.region_number = NUM_W'(found_r) + NUM_W'(1);
  end

  assign in_ch.ready          = (state_r == S_IDLE);
  assign out_ch.valid         = out_valid_r;
  assign out_ch.top_row       = out_rec_r.top_row;
  assign out_ch.left_col      = out_rec_r.left_col;
  assign out_ch.region_width  = out_rec_r.region_width;
  assign out_ch.region_height = out_rec_r.region_height;
  assign out_ch.region_area   = out_rec_r.region_area;
  assign out_ch.region_number = out_rec_r.region_number;
  assign out_ch.last_of_run   = out_last_r;

  // Controller: next state and all register updates.
  always_comb begin
    state_nxt     = state_r;
    col_nxt       = col_r;
    row_nxt       = row_r;
    left_nxt      = left_r;
    run_start_nxt = run_start_r;
    run_len_nxt   = run_len_r;
    run_opens_nxt = run_opens_r;
    found_nxt     = found_r;
    pix_nxt       = pix_r;
    upper_nxt     = upper_r;
    idx_nxt       = idx_r;
    count_nxt     = count_r;
    emits_nxt     = emits_r;
    valid_nxt     = valid_r;
    uvalid_nxt    = uvalid_r;
    pend_v_nxt    = pend_v_r;
    pend_nxt      = pend_r;
    out_rec_nxt   = out_rec_r;
    out_last_nxt  = out_last_r;
    out_valid_nxt = out_valid_r;
    o_re          = 1'b0;
    o_we          = 1'b0;
    o_waddr       = idx_r;
    o_wdata       = judge.entry;
    u_re          = 1'b0;
    u_we          = 1'b0;
    emit_go       = 1'b0;

    if (out_valid_r && out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end

    unique case (state_r)
      S_IDLE: begin
        if (in_ch.valid) begin
          pix_nxt   = in_ch.pixel;
          u_re      = 1'b1;
          idx_nxt   = '0;
          count_nxt = '0;
          emits_nxt = '0;
          state_nxt = S_UPPER;
        end
      end
      S_UPPER: begin
        upper_nxt = uvalid_r[col_r] & urd_r;
        state_nxt = S_SCAN;
      end
      S_SCAN: begin
        if (valid_r[idx_r]) begin
          o_re      = 1'b1;
          state_nxt = S_PROC;
        end else if (idx_r == COL_W'(MAX_WIDTH - 1)) begin
          state_nxt = S_OPEN;
        end else begin
          idx_nxt = idx_r + COL_W'(1);
        end
      end
      S_PROC: begin
        // Hold while a record must leave but the output is still occupied.
        if (!(judge.emit && pend_v_r && !out_free)) begin
          o_we = 1'b1;
          if (judge.emit) begin
            emit_go          = 1'b1;
            valid_nxt[idx_r] = 1'b0;
          end else begin
            count_nxt = count_r + CNT_W'(1);
          end
          if (idx_r == COL_W'(MAX_WIDTH - 1)) begin
            state_nxt = S_OPEN;
          end else begin
            idx_nxt   = idx_r + COL_W'(1);
            state_nxt = S_SCAN;
          end
        end
      end
      S_OPEN: begin
        if (pix_r) begin
          if (!left_r) begin
            run_start_nxt = col_r;
            run_len_nxt   = DIM_W'(1);
            run_opens_nxt = !upper_r;
          end else if (run_len_r < RUN_SAT) begin
            run_len_nxt = run_len_r + DIM_W'(1);
          end
        end
        if ((!pix_r && (run_len_r != '0)) || (pix_r && row_end)) begin
          if (run_opens_nxt && (count_r < CNT_W'(MAX_OPEN))) begin
            o_we                     = 1'b1;
            o_waddr                  = run_start_nxt;
            o_wdata.top              = row_r;
            o_wdata.span             = run_len_nxt;
            o_wdata.height           = DIM_W'(1);
            o_wdata.row_ok           = 1'b1;
            valid_nxt[run_start_nxt] = 1'b1;
          end
          run_len_nxt   = '0;
          run_opens_nxt = 1'b0;
        end
        left_nxt          = row_end ? 1'b0 : pix_r;
        u_we              = 1'b1;
        uvalid_nxt[col_r] = 1'b1;
        if (frame_end) begin
          idx_nxt   = '0;
          state_nxt = S_FLUSH_SCAN;
        end else begin
          if (row_end) begin
            col_nxt = '0;
            row_nxt = row_r + ROW_W'(1);
          end else begin
            col_nxt = col_r + COL_W'(1);
          end
          state_nxt = S_LAST;
        end
      end
      S_FLUSH_SCAN: begin
        if (valid_r[idx_r]) begin
          o_re      = 1'b1;
          state_nxt = S_FLUSH_PROC;
        end else if (idx_r == COL_W'(MAX_WIDTH - 1)) begin
          state_nxt = S_CLEAR;
        end else begin
          idx_nxt = idx_r + COL_W'(1);
        end
      end
      S_FLUSH_PROC: begin
        if (!(pend_v_r && !out_free)) begin
          emit_go          = 1'b1;
          valid_nxt[idx_r] = 1'b0;
          if (idx_r == COL_W'(MAX_WIDTH - 1)) begin
            state_nxt = S_CLEAR;
          end else begin
            idx_nxt   = idx_r + COL_W'(1);
            state_nxt = S_FLUSH_SCAN;
          end
        end
      end
      S_CLEAR: begin
        valid_nxt     = '0;
        uvalid_nxt    = '0;
        col_nxt       = '0;
        row_nxt       = '0;
        left_nxt      = 1'b0;
        run_start_nxt = '0;
        run_len_nxt   = '0;
        run_opens_nxt = 1'b0;
        found_nxt     = '0;
        state_nxt     = S_LAST;
      end
      S_LAST: begin
        if (!pend_v_r) begin
          state_nxt = S_IDLE;
        end else if (out_free) begin
          out_rec_nxt   = pend_r;
          out_last_nxt  = 1'b1;
          out_valid_nxt = 1'b1;
          pend_v_nxt    = 1'b0;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase

    // A new record pushes the pending one, which is then not the last, out.
    // Once the limit of records for one pixel is reached, a closing region
    // is removed without a record and without taking a number.
    if (emit_go && (emits_r != CNT_W'(RESULT_LIMIT))) begin
      if (pend_v_r) begin
        out_rec_nxt   = pend_r;
        out_last_nxt  = 1'b0;
        out_valid_nxt = 1'b1;
      end
      pend_nxt   = emit_rec;
      pend_v_nxt = 1'b1;
      emits_nxt  = emits_r + CNT_W'(1);
      if (found_r != FOUND_SAT) begin
        found_nxt = found_r + FOUND_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      width_cfg_r  <= DIM_W'(MAX_WIDTH);
      height_cfg_r <= DIM_W'(MAX_HEIGHT);
      col_r        <= '0;
      row_r        <= '0;
      left_r       <= 1'b0;
      run_start_r  <= '0;
      run_len_r    <= '0;
      run_opens_r  <= 1'b0;
      found_r      <= '0;
      idx_r        <= '0;
      count_r      <= '0;
      emits_r      <= '0;
      valid_r      <= '0;
      uvalid_r     <= '0;
      pend_v_r     <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      if (cfg_we && (cfg_index == REG_IMAGE_WIDTH)) begin
        width_cfg_r <= cfg_data;
      end
      if (cfg_we && (cfg_index == REG_IMAGE_HEIGHT)) begin
        height_cfg_r <= cfg_data;
      end
      col_r       <= col_nxt;
      row_r       <= row_nxt;
      left_r      <= left_nxt;
      run_start_r <= run_start_nxt;
      run_len_r   <= run_len_nxt;
      run_opens_r <= run_opens_nxt;
      found_r     <= found_nxt;
      idx_r       <= idx_nxt;
      count_r     <= count_nxt;
      emits_r     <= emits_nxt;
      valid_r     <= valid_nxt;
      uvalid_r    <= uvalid_nxt;
      pend_v_r    <= pend_v_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload registers carry no reset.
  always_ff @(posedge clk) begin
    pix_r      <= pix_nxt;
    upper_r    <= upper_nxt;
    pend_r     <= pend_nxt;
    out_rec_r  <= out_rec_nxt;
    out_last_r <= out_last_nxt;
  end

  always_ff @(posedge clk) begin
    if (o_we) begin
      omem[o_waddr] <= o_wdata;
    end
    if (o_re) begin
      ord_r <= omem[idx_r];
    end
  end

  always_ff @(posedge clk) begin
    if (u_we) begin
      umem[col_r] <= pix_r;
    end
    if (u_re) begin
      urd_r <= umem[col_r];
    end
  end

endmodule
`default_nettype wire

// ===== sim/testbench.sv =====
// Self-checking bench for binary_rectangle_region_finder: drives pixel words,
// predicts the region records and compares them. Depends on brrf_pkg and brrf_if.
`default_nettype none
module testbench;
  import brrf_pkg::*;

  // One expected region record, the fields as wide as on the result channel.
  typedef struct {
    logic [ROW_W-1:0]  top_row;
    logic [COL_W-1:0]  left_col;
    logic [DIM_W-1:0]  region_width;
    logic [DIM_W-1:0]  region_height;
    logic [AREA_W-1:0] region_area;
    logic [NUM_W-1:0]  region_number;
    logic              last_of_run;
  } region_rec_t;

  logic clk;
  logic rst_n;
  logic cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [DIM_W-1:0] cfg_data;

  brrf_in_if  in_ch ();
  brrf_out_if out_ch ();

  binary_rectangle_region_finder u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch.sink),
    .out_ch    (out_ch.source),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  initial clk = 1'b0;
  always #10 clk = ~clk;

  // The bench's own copy of the finder: settings, the pixel line above, the
  // open region table indexed by left column, and the scan position.
  logic [DIM_W-1:0]  set_width;
  logic [DIM_W-1:0]  set_height;
  bit                line_above [MAX_WIDTH];
  bit                is_open    [MAX_WIDTH];
  int unsigned       open_row   [MAX_WIDTH];
  int unsigned       open_wide  [MAX_WIDTH];
  int unsigned       open_tall  [MAX_WIDTH];
  bit                span_full  [MAX_WIDTH];
  int unsigned       cur_row;
  int unsigned       cur_col;
  bit                prev_pix;
  int unsigned       run_col;
  int unsigned       run_len;
  bit                run_is_new;
  int unsigned       found;

  region_rec_t expected_regions [$];
  bit          pixel_queue [$];
  int unsigned mismatches;
  int unsigned regions_seen;

  function automatic int unsigned clamp_size(logic [DIM_W-1:0] v, int unsigned lim);
    if (v == 0) return 1;
    if (v > lim) return lim;
    return v;
  endfunction

  function automatic void clear_image();
    for (int i = 0; i < MAX_WIDTH; i++) begin
      line_above[i] = 1'b0;
      is_open[i] = 1'b0;
      open_row[i] = 0;
      open_wide[i] = 0;
      open_tall[i] = 0;
      span_full[i] = 1'b0;
    end
    cur_row = 0;
    cur_col = 0;
    prev_pix = 1'b0;
    run_col = 0;
    run_len = 0;
    run_is_new = 1'b0;
    found = 0;
  endfunction

  // Closes the region whose left edge is at column lc and queues its record.
  function automatic void close_region(int unsigned lc, ref region_rec_t recs[$]);
    region_rec_t r;
    int unsigned num;
    if (recs.size() >= RESULT_LIMIT) return;
    num = found + 1;
    if (found < 2047) found++;
    r.top_row       = ROW_W'(open_row[lc]);
    r.left_col      = COL_W'(lc);
    r.region_width  = DIM_W'(open_wide[lc]);
    r.region_height = DIM_W'(open_tall[lc]);
    r.region_area   = AREA_W'(open_wide[lc] * open_tall[lc]);
    r.region_number = NUM_W'(num);
    r.last_of_run   = 1'b0;
    recs.push_back(r);
  endfunction

  // Advances the finder by one accepted pixel and queues the records it closes.
  function automatic void step_pixel(bit pix);
    region_rec_t recs [$];
    int unsigned w, h, col, upper, still_open, last_col;
    bit row_end, frame_end, judge;
    w = clamp_size(set_width, MAX_WIDTH);
    h = clamp_size(set_height, MAX_HEIGHT);
    col = cur_col;
    still_open = 0;
    row_end = col >= w - 1;
    frame_end = row_end && cur_row >= h - 1;
    if (col >= MAX_WIDTH) col = MAX_WIDTH - 1;
    upper = line_above[col];
    line_above[col] = pix;

    // Each open region is judged at its last span column, or at the row end
    // when its span runs past the edge of a narrowed row.
    for (int unsigned lc = 0; lc < MAX_WIDTH; lc++) begin
      if (!is_open[lc]) continue;
      last_col = lc + open_wide[lc] - 1;
      if (lc <= col && col <= last_col && !pix) span_full[lc] = 1'b0;
      judge = (col == last_col) || (row_end && last_col > col);
      if (judge) begin
        if (span_full[lc]) begin
          if (open_tall[lc] < 127) open_tall[lc]++;
        end else begin
          close_region(lc, recs);
          is_open[lc] = 1'b0;
        end
        span_full[lc] = 1'b1;
      end
      if (is_open[lc]) still_open++;
    end

    if (pix) begin
      if (!prev_pix) begin
        run_col = col;
        run_len = 1;
        run_is_new = (upper == 0);
      end else if (run_len < 127) begin
        run_len++;
      end
    end
    // A run that ends opens a region if it started below a background pixel
    // and the table still has room; otherwise it is silently dropped.
    if ((!pix && run_len > 0) || (pix && row_end)) begin
      if (run_is_new && still_open < MAX_OPEN && run_col < MAX_WIDTH) begin
        is_open[run_col] = 1'b1;
        open_row[run_col] = cur_row;
        open_wide[run_col] = run_len;
        open_tall[run_col] = 1;
        span_full[run_col] = 1'b1;
      end
      run_len = 0;
      run_is_new = 1'b0;
    end
    prev_pix = row_end ? 1'b0 : pix;

    if (frame_end) begin
      for (int unsigned lc = 0; lc < MAX_WIDTH; lc++) begin
        if (is_open[lc]) begin
          close_region(lc, recs);
          is_open[lc] = 1'b0;
        end
      end
      clear_image();
    end else if (row_end) begin
      cur_col = 0;
      cur_row++;
    end else begin
      cur_col = col + 1;
    end

    if (recs.size() > 0) recs[recs.size() - 1].last_of_run = 1'b1;
    foreach (recs[i]) expected_regions.push_back(recs[i]);
  endfunction

  task automatic report(input string field, input int unsigned got, input int unsigned want);
    $display("ERROR at %0t: %s is %0d, expected %0d", $realtime, field, got, want);
    mismatches++;
  endtask

  // Driver: pixels go out in bursts of random length separated by random gaps.
  // The prediction is made at the edge where a word is accepted.
  int unsigned burst_left;
  int unsigned gap_left;

  always @(posedge clk) begin
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
      in_ch.pixel <= 1'b0;
      burst_left = 0;
      gap_left = 0;
    end else if (!in_ch.valid || in_ch.ready) begin
      if (in_ch.valid && in_ch.ready) step_pixel(in_ch.pixel);
      if (gap_left > 0) begin
        gap_left--;
        in_ch.valid <= 1'b0;
      end else if (pixel_queue.size() > 0) begin
        in_ch.valid <= 1'b1;
        in_ch.pixel <= pixel_queue.pop_front();
        if (burst_left == 0) burst_left = $urandom_range(1, 12);
        burst_left--;
        if (burst_left == 0) gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 40);
      end else begin
        in_ch.valid <= 1'b0;
      end
    end
  end

  // Monitor: the receiver switches at random between always ready,
  // mostly ready and mostly stalled, and checks each accepted record.
  int unsigned stall_mode;
  int unsigned stall_count;

  always @(posedge clk) begin
    region_rec_t want;
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
      stall_mode = 0;
      stall_count = 0;
    end else begin
      if (stall_count == 0) begin
        stall_mode = $urandom_range(0, 2);
        stall_count = 150;
      end
      stall_count--;
      case (stall_mode)
        0: begin
          out_ch.ready <= 1'b1;
        end
        1: begin
          out_ch.ready <= ($urandom_range(0, 9) < 7);
        end
        default: begin
          out_ch.ready <= ($urandom_range(0, 9) < 2);
        end
      endcase
      if (out_ch.valid && out_ch.ready) begin
        regions_seen++;
        if (expected_regions.size() == 0) begin
          report("records pending", 0, 1);
        end else begin
          want = expected_regions.pop_front();
          if (out_ch.top_row != want.top_row)
            report("top_row", out_ch.top_row, want.top_row);
          if (out_ch.left_col != want.left_col)
            report("left_col", out_ch.left_col, want.left_col);
          if (out_ch.region_width != want.region_width)
            report("region_width", out_ch.region_width, want.region_width);
          if (out_ch.region_height != want.region_height)
            report("region_height", out_ch.region_height, want.region_height);
          if (out_ch.region_area != want.region_area)
            report("region_area", out_ch.region_area, want.region_area);
          if (out_ch.region_number != want.region_number)
            report("region_number", out_ch.region_number, want.region_number);
          if (out_ch.last_of_run != want.last_of_run)
            report("last_of_run", out_ch.last_of_run, want.last_of_run);
        end
      end
    end
  end

  // Waits until every queued pixel is taken and every record has come back,
  // then lets the block finish any pixel that closes nothing.
  task automatic wait_idle();
    while (pixel_queue.size() > 0 || in_ch.valid || expected_regions.size() > 0)
      @(posedge clk);
    repeat (300) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [DIM_W-1:0] value);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx == REG_IMAGE_WIDTH) set_width = value;
    else set_height = value;
  endtask

  task automatic set_image(input logic [DIM_W-1:0] w, input logic [DIM_W-1:0] h);
    write_reg(REG_IMAGE_WIDTH, w);
    write_reg(REG_IMAGE_HEIGHT, h);
  endtask

  task automatic push_bits(input string bits);
    @(negedge clk);
    foreach (bits[i]) pixel_queue.push_back(bits[i] == "1");
  endtask

  int unsigned random_pixels;

  initial begin
    int unsigned w, h, density, pick;
    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_index = REG_IMAGE_WIDTH;
    cfg_data = '0;
    in_ch.valid = 1'b0;
    in_ch.pixel = 1'b0;
    out_ch.ready = 1'b0;
    mismatches = 0;
    regions_seen = 0;
    random_pixels = 0;
    set_width = DIM_W'(64);
    set_height = DIM_W'(64);
    clear_image();
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // A small image: a region that grows a row and then breaks, a region
    // that starts on the last row, and a right-edge run judged at row end.
    set_image(DIM_W'(4), DIM_W'(3));
    push_bits({"0110", "0111", "1001"});
    wait_idle();

    // Zero sizes act as one: every pixel is a whole frame.
    set_image(DIM_W'(0), DIM_W'(0));
    push_bits("1101");
    wait_idle();

    // Oversized width clamps to the full row. The second row opens a region
    // in every third column pair, more than the table holds, so some drop.
    set_image(DIM_W'(127), DIM_W'(2));
    @(negedge clk);
    for (int c = 0; c < MAX_WIDTH; c++) pixel_queue.push_back(c % 3 == 0);
    for (int c = 0; c < MAX_WIDTH; c++) pixel_queue.push_back(c % 3 != 1);
    wait_idle();

    // Narrowing the image in the middle of a row ends the row and, with a
    // lower height, the frame; a region wider than the new row is judged there.
    set_image(DIM_W'(8), DIM_W'(127));
    push_bits({"01111100", "01111"});
    wait_idle();
    set_image(DIM_W'(3), DIM_W'(2));
    push_bits("1");
    wait_idle();

    // Random frames, mostly small, each with a density of its own.
    while (random_pixels < 24) begin
      pick = $urandom_range(0, 9);
      if (pick == 0) begin
        w = 64;
        h = 1;
        set_image(($urandom_range(0, 1) == 0) ? DIM_W'(64) : DIM_W'(127), DIM_W'(h));
      end else if (pick == 1) begin
        w = 1;
        h = $urandom_range(1, 8);
        set_image(DIM_W'(0), DIM_W'(h));
      end else begin
        w = $urandom_range(1, 8);
        h = $urandom_range(1, 6);
        set_image(DIM_W'(w), DIM_W'(h));
      end
      density = $urandom_range(20, 90);
      @(negedge clk);
      for (int i = 0; i < w * h; i++) pixel_queue.push_back($urandom_range(0, 99) < density);
      random_pixels += w * h;
      wait_idle();
    end

    if (mismatches == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

  initial begin
    #40000000;
    $display("Mismatches found");
    $finish;
  end

endmodule
`default_nettype wire
